@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/twd_pkg.sv @@
// ----------------------------------------------------------------------------
// Twist deformer package
// Angle constants, CORDIC arctangent table and register codes.
// ----------------------------------------------------------------------------
package twd_pkg;

   localparam int QUO_W    = 33;
   localparam int ANG_W    = 35;
   localparam int CORDIC_W = 34;

   localparam logic [QUO_W:0] TWO_PI_Q30 = 34'd6746518852;

   localparam logic signed [ANG_W-1:0] TWO_PI_S  = 35'sd6746518852;
   localparam logic signed [ANG_W-1:0] PI_S      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_S = 35'sd1686629713;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] ROUND_Q29 = 34'sd536870912;

   typedef enum logic [1:0] {
      REG_TWIST_ANGLE = 2'd0,
      REG_Y_MIN       = 2'd1,
      REG_Y_MAX       = 2'd2
   } twd_reg_type;

   function automatic logic signed [CORDIC_W-1:0] twd_atan(input int idx);
      logic signed [CORDIC_W-1:0] v;
      unique case (idx)
         0:  v = 34'sh03243F6A8;
         1:  v = 34'sh01DAC6705;
         2:  v = 34'sh00FADBAFC;
         3:  v = 34'sh007F56EA6;
         4:  v = 34'sh003FEAB76;
         5:  v = 34'sh001FFD55B;
         6:  v = 34'sh000FFFAAA;
         7:  v = 34'sh0007FFF55;
         8:  v = 34'sh0003FFFEA;
         9:  v = 34'sh0001FFFFD;
         10: v = 34'sh0000FFFFF;
         11: v = 34'sh00007FFFF;
         12: v = 34'sh00003FFFF;
         13: v = 34'sh00001FFFF;
         14: v = 34'sh00000FFFF;
         15: v = 34'sh000007FFF;
         16: v = 34'sh000003FFF;
         17: v = 34'sh000001FFF;
         18: v = 34'sh000000FFF;
         19: v = 34'sh0000007FF;
         20: v = 34'sh0000003FF;
         21: v = 34'sh0000001FF;
         22: v = 34'sh0000000FF;
         23: v = 34'sh00000007F;
         24: v = 34'sh00000003F;
         25: v = 34'sh00000001F;
         26: v = 34'sh00000000F;
         27: v = 34'sh000000008;
         28: v = 34'sh000000004;
         29: v = 34'sh000000002;
         30: v = 34'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/twd_req_if.sv @@
// ----------------------------------------------------------------------------
// Vertex request channel
// Valid/ready channel carrying one input vertex per transaction.
// ----------------------------------------------------------------------------
interface twd_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;
   logic signed [COORD_WIDTH-1:0] z_in;

   modport source (output valid, x_in, y_in, z_in, input ready);
   modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

@@ hw/rtl/twd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Vertex response channel
// Valid/ready channel carrying one twisted vertex per transaction.
// ----------------------------------------------------------------------------
interface twd_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_out;
   logic signed [COORD_WIDTH-1:0] y_out;
   logic signed [COORD_WIDTH-1:0] z_out;
   logic                          flat_box;

   modport source (output valid, x_out, y_out, z_out, flat_box, input ready);
   modport sink (input valid, x_out, y_out, z_out, flat_box, output ready);
endinterface

@@ hw/rtl/twd_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step that also keeps the quotient modulo two pi.
// ----------------------------------------------------------------------------
module twd_div_cell import twd_pkg::*; #(
   parameter int W   = 32,
   parameter int NB  = 77,
   parameter int BIT = 0,
   parameter int SW  = 98
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_i,
   input  logic [W-1:0]     r_i,
   input  logic [QUO_W-1:0] q_i,
   input  logic [NB-1:0]    num_i,
   input  logic [W-1:0]     d_i,
   input  logic [SW-1:0]    side_i,
   output logic             vld_o,
   output logic [W-1:0]     r_o,
   output logic [QUO_W-1:0] q_o,
   output logic [NB-1:0]    num_o,
   output logic [W-1:0]     d_o,
   output logic [SW-1:0]    side_o
);

   logic             vld_ff;
   logic [W-1:0]     r_ff, r_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [NB-1:0]    num_ff;
   logic [W-1:0]     d_ff;
   logic [SW-1:0]    side_ff;
   logic [W:0]       rs;
   logic             ge;
   logic [QUO_W:0]   q2, q3;
   logic [QUO_W-1:0] q2m;

   always_comb begin
      rs   = {r_i, num_i[BIT]};
      ge   = rs >= {1'b0, d_i};
      r_in = ge ? W'(rs - {1'b0, d_i}) : W'(rs);
      q2   = {q_i, 1'b0};
      q2m  = (q2 >= TWO_PI_Q30) ? QUO_W'(q2 - TWO_PI_Q30) : QUO_W'(q2);
      q3   = {1'b0, q2m} + (QUO_W+1)'(ge);
      q_in = (q3 >= TWO_PI_Q30) ? QUO_W'(q3 - TWO_PI_Q30) : QUO_W'(q3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         q_ff    <= q_in;
         num_ff  <= num_i;
         d_ff    <= d_i;
         side_ff <= side_i;
      end
   end

   assign vld_o  = vld_ff;
   assign r_o    = r_ff;
   assign q_o    = q_ff;
   assign num_o  = num_ff;
   assign d_o    = d_ff;
   assign side_o = side_ff;

endmodule

@@ hw/rtl/twd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module twd_cordic_cell import twd_pkg::*; #(
   parameter int STAGE = 0,
   parameter int SW    = 98
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_i,
   input  logic signed [CORDIC_W-1:0] cx_i,
   input  logic signed [CORDIC_W-1:0] cy_i,
   input  logic signed [CORDIC_W-1:0] cz_i,
   input  logic [SW-1:0]              side_i,
   output logic                       vld_o,
   output logic signed [CORDIC_W-1:0] cx_o,
   output logic signed [CORDIC_W-1:0] cy_o,
   output logic signed [CORDIC_W-1:0] cz_o,
   output logic [SW-1:0]              side_o
);

   localparam logic signed [CORDIC_W-1:0] ATAN = twd_atan(STAGE);

   logic                       vld_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [CORDIC_W-1:0] dx, dy;
   logic [SW-1:0]              side_ff;

   always_comb begin
      dx = cy_i >>> STAGE;
      dy = cx_i >>> STAGE;
      if (!cz_i[CORDIC_W-1]) begin
         cx_in = cx_i - dx;
         cy_in = cy_i + dy;
         cz_in = cz_i - ATAN;
      end else begin
         cx_in = cx_i + dx;
         cy_in = cy_i - dy;
         cz_in = cz_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         side_ff <= side_i;
      end
   end

   assign vld_o  = vld_ff;
   assign cx_o   = cx_ff;
   assign cy_o   = cy_ff;
   assign cz_o   = cz_ff;
   assign side_o = side_ff;

endmodule

@@ hw/rtl/vertex_twist_deform.sv @@
// Pipeline: one divider cell per quotient bit and one CORDIC cell per stage.
// Throughput: one vertex per cycle while the skid entry is empty; a two-entry
// output buffer absorbs stalls, and requests are held off while it is full.
// Reset: synchronous; registers return to twist 0, y_min 0, y_max 1.0.
// ----------------------------------------------------------------------------
// Vertex twist deformer
// Rotates each vertex about Y by an angle proportional to its height.
// ----------------------------------------------------------------------------
module vertex_twist_deform import twd_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   twd_req_if.sink   req_bus,
   twd_rsp_if.source rsp_bus,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0] paddr,
   input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
   output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
   output logic pready
);

`include "assert_macros.svh"

   localparam int W          = COORD_WIDTH;
   localparam int NB         = 2 * W + 13;
   localparam int NCHK       = (W + 15) / 16;
   localparam int SW         = 3 * W + 2;
   localparam int XH_W       = W - 15;
   localparam int PH_W       = CORDIC_W + XH_W;
   localparam int PL_W       = CORDIC_W + 17;
   localparam int SUM_W      = PH_W + 2;
   localparam int APB_W      = (W > 32) ? 64 : 32;
   localparam int ADDR_SHIFT = (W > 32) ? 3 : 2;
   localparam int ADDR_W     = ADDR_SHIFT + 2;
   localparam int RES_W      = 3 * W + 1;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   // Configuration registers
   logic signed [W-1:0] twist_ff, ymin_ff, ymax_ff;
   twd_reg_type         reg_sel;
   logic                wr_en;

   assign reg_sel = twd_reg_type'(paddr[ADDR_W-1:ADDR_SHIFT]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         twist_ff <= '0;
         ymin_ff  <= '0;
         ymax_ff  <= W'(17'h10000);
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_TWIST_ANGLE: twist_ff <= W'(pwdata);
            REG_Y_MIN:       ymin_ff  <= W'(pwdata);
            REG_Y_MAX:       ymax_ff  <= W'(pwdata);
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_TWIST_ANGLE: prdata = APB_W'(twist_ff);
         REG_Y_MIN:       prdata = APB_W'(ymin_ff);
         REG_Y_MAX:       prdata = APB_W'(ymax_ff);
         default:         prdata = '0;
      endcase
   end

   // Pipeline control
   logic en;
   logic skid_vld_ff, skid_vld_in, out_vld_ff, out_vld_in;
   logic [RES_W-1:0] skid_res_ff, skid_res_in, out_res_ff, out_res_in;

   assign en            = !skid_vld_ff;
   assign req_bus.ready = en;

   // Front end: differences, magnitudes, product
   logic                s0_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [W-1:0] s0_x_ff, s0_y_ff, s0_z_ff, s0_tw_ff;
   logic signed [W:0]   s0_dy_ff, s0_den_ff;
   logic [W-1:0]        s1_mtw_ff, s1_mdy_ff, s1_mden_ff, s2_mden_ff, s3_mden_ff;
   logic [SW-1:0]       s1_side_ff, s2_side_ff, s3_side_ff;
   logic [W+15:0]       s2_pp_ff [NCHK];
   logic [NB-1:0]       s3_num_ff, s3_num_in;
   logic [NCHK*16-1:0]  mdy_ext;
   logic [2*W-1:0]      prod;

   assign mdy_ext = (NCHK*16)'(s1_mdy_ff);

   always_comb begin
      prod = '0;
      for (int k = 0; k < NCHK; k++) begin
         prod = prod + ((2*W)'(s2_pp_ff[k]) << (16 * k));
      end
      s3_num_in = {prod[2*W-2:0], 14'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff   <= req_bus.x_in;
         s0_y_ff   <= req_bus.y_in;
         s0_z_ff   <= req_bus.z_in;
         s0_tw_ff  <= twist_ff;
         s0_dy_ff  <= (W+1)'(req_bus.y_in) - (W+1)'(ymin_ff);
         s0_den_ff <= (W+1)'(ymax_ff) - (W+1)'(ymin_ff);

         s1_mtw_ff  <= s0_tw_ff[W-1] ? W'(-s0_tw_ff) : W'(s0_tw_ff);
         s1_mdy_ff  <= s0_dy_ff[W] ? W'(-s0_dy_ff) : W'(s0_dy_ff);
         s1_mden_ff <= s0_den_ff[W] ? W'(-s0_den_ff) : W'(s0_den_ff);
         s1_side_ff <= {s0_tw_ff[W-1] ^ s0_dy_ff[W] ^ s0_den_ff[W], s0_den_ff == '0,
                        s0_x_ff, s0_y_ff, s0_z_ff};

         for (int k = 0; k < NCHK; k++) begin
            s2_pp_ff[k] <= s1_mtw_ff * mdy_ext[16*k +: 16];
         end
         s2_mden_ff <= s1_mden_ff;
         s2_side_ff <= s1_side_ff;

         s3_num_ff  <= s3_num_in;
         s3_mden_ff <= s2_mden_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // Divider chain
   logic             dv [NB+1];
   logic [W-1:0]     dr [NB+1];
   logic [QUO_W-1:0] dq [NB+1];
   logic [NB-1:0]    dn [NB+1];
   logic [W-1:0]     dd [NB+1];
   logic [SW-1:0]    ds [NB+1];

   assign dv[0] = s3_vld_ff;
   assign dr[0] = '0;
   assign dq[0] = '0;
   assign dn[0] = s3_num_ff;
   assign dd[0] = s3_mden_ff;
   assign ds[0] = s3_side_ff;

   for (genvar k = 0; k < NB; k++) begin : g_div
      twd_div_cell #(.W(W), .NB(NB), .BIT(NB - 1 - k), .SW(SW)) u_cell (
         .clock (clock), .reset (reset), .en (en),
         .vld_i (dv[k]), .r_i (dr[k]), .q_i (dq[k]), .num_i (dn[k]),
         .d_i (dd[k]), .side_i (ds[k]),
         .vld_o (dv[k+1]), .r_o (dr[k+1]), .q_o (dq[k+1]), .num_o (dn[k+1]),
         .d_o (dd[k+1]), .side_o (ds[k+1])
      );
   end

   // Angle sign and range folding
   logic                       f1_vld_ff, f2_vld_ff, f3_vld_ff;
   logic [QUO_W-1:0]           f1_ang_ff;
   logic signed [ANG_W-1:0]    f2_ang_ff, f2_ext;
   logic signed [CORDIC_W-1:0] f3_ang_ff;
   logic [SW-1:0]              f1_side_ff, f2_side_ff, f3_side_ff;
   logic                       neg_div;

   assign neg_div = ds[NB][SW-1];
   assign f2_ext  = $signed({2'b00, f1_ang_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ang_ff  <= (neg_div && dq[NB] != '0) ?
                       QUO_W'(TWO_PI_Q30 - {1'b0, dq[NB]}) : dq[NB];
         f1_side_ff <= ds[NB];

         f2_ang_ff  <= (f2_ext > PI_S) ? f2_ext - TWO_PI_S : f2_ext;
         f2_side_ff <= f1_side_ff;

         priority if (f2_ang_ff > HALF_PI_S) begin
            f3_ang_ff  <= CORDIC_W'(f2_ang_ff - PI_S);
            f3_side_ff <= {1'b1, f2_side_ff[SW-2:0]};
         end else if (f2_ang_ff < -HALF_PI_S) begin
            f3_ang_ff  <= CORDIC_W'(f2_ang_ff + PI_S);
            f3_side_ff <= {1'b1, f2_side_ff[SW-2:0]};
         end else begin
            f3_ang_ff  <= CORDIC_W'(f2_ang_ff);
            f3_side_ff <= {1'b0, f2_side_ff[SW-2:0]};
         end
      end
   end

   // CORDIC chain
   logic                       cv [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] cx [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] cy [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] cz [CORDIC_STAGES+1];
   logic [SW-1:0]              cs [CORDIC_STAGES+1];

   assign cv[0] = f3_vld_ff;
   assign cx[0] = GAIN_Q30;
   assign cy[0] = '0;
   assign cz[0] = f3_ang_ff;
   assign cs[0] = f3_side_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      twd_cordic_cell #(.STAGE(i), .SW(SW)) u_cell (
         .clock (clock), .reset (reset), .en (en),
         .vld_i (cv[i]), .cx_i (cx[i]), .cy_i (cy[i]), .cz_i (cz[i]), .side_i (cs[i]),
         .vld_o (cv[i+1]), .cx_o (cx[i+1]), .cy_o (cy[i+1]), .cz_o (cz[i+1]),
         .side_o (cs[i+1])
      );
   end

   // Rotation products, rounding and saturation
   logic                       d0_vld_ff, d1_vld_ff, d2_vld_ff, d3_vld_ff;
   logic signed [CORDIC_W-1:0] d0_c_ff, d0_s_ff;
   logic [SW-1:0]              d0_side_ff, d1_side_ff, d2_side_ff;
   logic signed [W-1:0]        d0_x, d0_z;
   logic signed [W:0]          d0_xe, d0_ze;
   logic signed [XH_W-1:0]     xh, zh;
   logic signed [16:0]         xl, zl;
   logic signed [PH_W-1:0]     cxh_ff, szh_ff, czh_ff, sxh_ff;
   logic signed [PL_W-1:0]     cxl_ff, szl_ff, czl_ff, sxl_ff;
   logic signed [PH_W:0]       hx_ff, hz_ff;
   logic signed [PL_W:0]       lx_ff, lz_ff;
   logic signed [SUM_W-1:0]    vx, vz;
   logic signed [W-1:0]        xo, zo, d2_x, d2_y, d2_z;
   logic [RES_W-1:0]           d3_res_ff, d3_res_in;

   assign d0_x  = $signed(d0_side_ff[3*W-1:2*W]);
   assign d0_z  = $signed(d0_side_ff[W-1:0]);
   assign d0_xe = (W+1)'(d0_x);
   assign d0_ze = (W+1)'(d0_z);
   assign xh    = $signed(d0_xe[W:16]);
   assign zh    = $signed(d0_ze[W:16]);
   assign xl    = $signed({1'b0, d0_x[15:0]});
   assign zl    = $signed({1'b0, d0_z[15:0]});

   assign d2_x = $signed(d2_side_ff[3*W-1:2*W]);
   assign d2_y = $signed(d2_side_ff[2*W-1:W]);
   assign d2_z = $signed(d2_side_ff[W-1:0]);

   always_comb begin
      vx = (SUM_W'(hx_ff) + SUM_W'(lx_ff >>> 16)) >>> 14;
      vz = (SUM_W'(hz_ff) + SUM_W'(lz_ff >>> 16)) >>> 14;
      priority if (vx > SAT_HI) xo = SAT_HI[W-1:0];
      else if (vx < SAT_LO)     xo = SAT_LO[W-1:0];
      else                      xo = vx[W-1:0];
      priority if (vz > SAT_HI) zo = SAT_HI[W-1:0];
      else if (vz < SAT_LO)     zo = SAT_LO[W-1:0];
      else                      zo = vz[W-1:0];
      if (d2_side_ff[SW-2]) begin
         d3_res_in = {1'b1, d2_x, d2_y, d2_z};
      end else begin
         d3_res_in = {1'b0, xo, d2_y, zo};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_c_ff    <= cs[CORDIC_STAGES][SW-1] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
         d0_s_ff    <= cs[CORDIC_STAGES][SW-1] ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];
         d0_side_ff <= cs[CORDIC_STAGES];

         cxh_ff     <= d0_c_ff * xh;
         szh_ff     <= d0_s_ff * zh;
         czh_ff     <= d0_c_ff * zh;
         sxh_ff     <= d0_s_ff * xh;
         cxl_ff     <= d0_c_ff * xl;
         szl_ff     <= d0_s_ff * zl;
         czl_ff     <= d0_c_ff * zl;
         sxl_ff     <= d0_s_ff * xl;
         d1_side_ff <= d0_side_ff;

         hx_ff      <= (PH_W+1)'(cxh_ff) + (PH_W+1)'(szh_ff);
         hz_ff      <= (PH_W+1)'(czh_ff) - (PH_W+1)'(sxh_ff);
         lx_ff      <= (PL_W+1)'(cxl_ff) + (PL_W+1)'(szl_ff) + (PL_W+1)'(ROUND_Q29);
         lz_ff      <= (PL_W+1)'(czl_ff) - (PL_W+1)'(sxl_ff) + (PL_W+1)'(ROUND_Q29);
         d2_side_ff <= d1_side_ff;

         d3_res_ff  <= d3_res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         d0_vld_ff <= 1'b0;
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         d3_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_bus.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         f1_vld_ff <= dv[NB];
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         d0_vld_ff <= cv[CORDIC_STAGES];
         d1_vld_ff <= d0_vld_ff;
         d2_vld_ff <= d1_vld_ff;
         d3_vld_ff <= d2_vld_ff;
      end
   end

   // Output register and skid entry
   logic last_go;

   assign last_go = en && d3_vld_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_res_in  = out_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      priority if (out_vld_ff && rsp_bus.ready) begin
         priority if (skid_vld_ff) begin
            out_res_in  = skid_res_ff;
            skid_vld_in = 1'b0;
         end else if (last_go) begin
            out_res_in = d3_res_ff;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (!out_vld_ff) begin
         if (last_go) begin
            out_res_in = d3_res_ff;
            out_vld_in = 1'b1;
         end
      end else if (last_go) begin
         skid_res_in = d3_res_ff;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_bus.valid    = out_vld_ff;
   assign rsp_bus.flat_box = out_res_ff[RES_W-1];
   assign rsp_bus.x_out    = $signed(out_res_ff[3*W-1:2*W]);
   assign rsp_bus.y_out    = $signed(out_res_ff[2*W-1:W]);
   assign rsp_bus.z_out    = $signed(out_res_ff[W-1:0]);

   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff)
   `ASSERT_NEXT(a_skid_holds, clock, reset, skid_vld_ff && !rsp_bus.ready, skid_vld_ff)
   `ASSERT_NEXT(a_stall_fills_skid, clock, reset, last_go && out_vld_ff && !rsp_bus.ready, skid_vld_ff)

endmodule

@@ dv/twd_twist_checker.sv @@
// ----------------------------------------------------------------------------
// Twist deformer checker
// Watches the vertex channels and the register port, predicts every twisted
// vertex from its own copy of the registers and compares field by field.
// ----------------------------------------------------------------------------
module twd_twist_checker import twd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   twd_req_if          req_mon,
   twd_rsp_if          rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               flat;
   } twisted_vertex_type;

   localparam longint TWO_PI = 64'd6746518852;
   localparam longint PI_RAD = 64'd3373259426;
   localparam longint HALF_PI = 64'd1686629713;
   localparam longint CORDIC_GAIN = 64'd652032874;

   localparam longint ATAN_TABLE [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   logic signed [31:0] twist_reg;
   logic signed [31:0] ymin_reg;
   logic signed [31:0] ymax_reg;
   twisted_vertex_type expected_vertices [$];

   assign pending = expected_vertices.size();

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [31:0] rotate_sum(longint a, longint x, longint b,
                                                     longint z);
      longint hi_part;
      longint lo_part;
      longint total;
      hi_part = a * (x >>> 16) + b * (z >>> 16);
      lo_part = a * (x & 64'hFFFF) + b * (z & 64'hFFFF) + (64'sd1 <<< 29);
      total = (hi_part + (lo_part >>> 16)) >>> 14;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      return total[31:0];
   endfunction

   function automatic twisted_vertex_type twist_vertex(logic signed [31:0] x,
                                                       logic signed [31:0] y,
                                                       logic signed [31:0] z);
      twisted_vertex_type res;
      longint          den;
      longint          dy;
      longint          ang;
      longint          cx;
      longint          cy;
      longint          cz;
      longint          dxs;
      longint          dys;
      logic [95:0]     num;
      logic [95:0]     quo;
      logic            negative;
      logic            flip;
      den = longint'(ymax_reg) - longint'(ymin_reg);
      dy = longint'(y) - longint'(ymin_reg);
      res.y = y;
      if (den == 0) begin
         res.x = x;
         res.z = z;
         res.flat = 1'b1;
         return res;
      end
      num = (96'(magnitude(longint'(twist_reg))) * 96'(magnitude(dy))) << 14;
      quo = num / 96'(magnitude(den));
      ang = longint'(quo % 96'(TWO_PI));
      negative = ((twist_reg < 0) != (dy < 0)) != (den < 0);
      if (negative && ang != 0) ang = TWO_PI - ang;
      flip = 1'b0;
      if (ang > PI_RAD) ang -= TWO_PI;
      if (ang > HALF_PI) begin
         ang -= PI_RAD;
         flip = 1'b1;
      end else if (ang < -HALF_PI) begin
         ang += PI_RAD;
         flip = 1'b1;
      end
      cx = CORDIC_GAIN;
      cy = 0;
      cz = ang;
      for (int i = 0; i < 24; i++) begin
         dxs = cy >>> i;
         dys = cx >>> i;
         if (cz >= 0) begin
            cx -= dxs;
            cy += dys;
            cz -= ATAN_TABLE[i];
         end else begin
            cx += dxs;
            cy -= dys;
            cz += ATAN_TABLE[i];
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      res.x = rotate_sum(cx, longint'(x), cy, longint'(z));
      res.z = rotate_sum(-cy, longint'(x), cx, longint'(z));
      res.flat = 1'b0;
      return res;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("Mismatch on %s: got %h, expected %h", field, got, want);
      fail_count++;
   endtask

   // Handshakes are sampled mid-cycle; a transaction completes at the next edge.
   always @(negedge clock) begin
      twisted_vertex_type want;
      if (reset) begin
         twist_reg = '0;
         ymin_reg = '0;
         ymax_reg = 32'sd65536;
         fail_count = 0;
         expected_vertices.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (twd_reg_type'(paddr[3:2]))
               REG_TWIST_ANGLE: twist_reg = pwdata;
               REG_Y_MIN:       ymin_reg = pwdata;
               REG_Y_MAX:       ymax_reg = pwdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_vertices.insert(expected_vertices.size(),
                                     twist_vertex(req_mon.x_in, req_mon.y_in,
                                                  req_mon.z_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_vertices.size() == 0) begin
               report("unexpected response", rsp_mon.x_out, 32'h0);
            end else begin
               want = expected_vertices.pop_front();
               if (rsp_mon.x_out !== want.x) report("x_out", rsp_mon.x_out, want.x);
               if (rsp_mon.y_out !== want.y) report("y_out", rsp_mon.y_out, want.y);
               if (rsp_mon.z_out !== want.z) report("z_out", rsp_mon.z_out, want.z);
               if (rsp_mon.flat_box !== want.flat)
                  report("flat_box", 32'(rsp_mon.flat_box), 32'(want.flat));
            end
         end
      end
   end

endmodule

@@ dv/tb_vertex_twist_deform.sv @@
// ----------------------------------------------------------------------------
// Twist deformer testbench
// Drives vertices and register settings with random gaps and stalls; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_vertex_twist_deform import twd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          sent;
   int          hold_left;
   logic        hold_done;
   int          cycles;
   logic signed [31:0] cur_ymin;
   logic signed [31:0] cur_ymax;

   twd_req_if #(.COORD_WIDTH(32)) req_ch ();
   twd_rsp_if #(.COORD_WIDTH(32)) rsp_ch ();

   vertex_twist_deform #(.COORD_WIDTH(32), .CORDIC_STAGES(24)) u_top (
      .clock(clock), .reset(reset), .req_bus(req_ch), .rsp_bus(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   twd_twist_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic quiet_stretch();
      return sent >= 1000 && sent < 1200;
   endfunction

   // The response side stalls at random, once for a long stretch.
   initial begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && sent >= 700) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_stretch()) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 34);
         end
      end
   end

   task automatic write_reg(twd_reg_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_box(logic [31:0] twist, logic [31:0] lo, logic [31:0] hi);
      while (pending != 0) @(posedge clock);
      write_reg(REG_TWIST_ANGLE, twist);
      write_reg(REG_Y_MIN, lo);
      write_reg(REG_Y_MAX, hi);
      cur_ymin = lo;
      cur_ymax = hi;
   endtask

   // Called at a rising edge; returns at the edge where the transaction completes.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while (!quiet_stretch() && $urandom_range(0, 99) < 34) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.x_in <= x;
      req_ch.y_in <= y;
      req_ch.z_in <= z;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sent++;
   endtask

   task automatic finish_burst();
      req_ch.valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 600000)) - 300000);
      endcase
   endfunction

   function automatic logic [31:0] random_height();
      longint span;
      if ($urandom_range(0, 99) < 30) return random_coord();
      span = longint'(cur_ymax) - longint'(cur_ymin);
      if (span < 0) span = -span;
      if (span > 64'd4294967295) span = 64'd4294967295;
      return 32'(longint'((cur_ymin < cur_ymax) ? cur_ymin : cur_ymax)
                 + longint'($urandom_range(0, 32'(span))));
   endfunction

   task automatic random_burst(int count);
      repeat (count) send_vertex(random_coord(), random_height(), random_coord());
      finish_burst();
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.x_in <= '0;
      req_ch.y_in <= '0;
      req_ch.z_in <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      sent = 0;
      cur_ymin = 0;
      cur_ymax = 32'sd65536;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: no twist at all.
      send_vertex(32'h0, 32'h0, 32'h0);
      send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
      send_vertex(32'h00010000, 32'h00008000, 32'hFFFF0000);
      finish_burst();

      // Half turn over a unit box, including heights beyond the box.
      set_box(32'd205887, 32'h0, 32'h00010000);
      @(posedge clock);
      send_vertex(32'h00010000, 32'h00008000, 32'h0);
      send_vertex(32'h00010000, 32'h00010000, 32'h00020000);
      send_vertex(32'h7FFFFFFF, 32'h00004000, 32'h7FFFFFFF);
      send_vertex(32'h80000000, 32'h00004000, 32'h80000000);
      send_vertex(32'h00030000, 32'hFFFE0000, 32'h00001234);
      send_vertex(32'h00030000, 32'h00500000, 32'hFFFD0000);
      send_vertex(32'h00000001, 32'h00018000, 32'hFFFFFFFF);
      finish_burst();

      // Flat box: vertices pass through.
      set_box(32'h00064000, 32'h000004D2, 32'h000004D2);
      @(posedge clock);
      send_vertex(32'h12345678, 32'h000004D2, 32'h9ABCDEF0);
      send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
      finish_burst();

      // Widest box and extreme twists, both orientations of the box.
      set_box(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      @(posedge clock);
      send_vertex(32'h00010000, 32'h7FFFFFFF, 32'h00010000);
      send_vertex(32'h7FFFFFFF, 32'h00000000, 32'h80000000);
      send_vertex(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
      finish_burst();
      set_box(32'h80000000, 32'h00010000, 32'h80000000);
      @(posedge clock);
      send_vertex(32'h00050000, 32'h7FFFFFFF, 32'hFFFB0000);
      send_vertex(32'h00050000, 32'h80000000, 32'h00050000);
      send_vertex(32'h7FFFFFFF, 32'h40000000, 32'h7FFFFFFF);
      finish_burst();

      set_box(32'd205887, 32'hFFFF0000, 32'h00010000);
      @(posedge clock);
      random_burst(400);
      set_box($urandom(), $urandom(), $urandom());
      @(posedge clock);
      random_burst(200);
      set_box(32'h000C90FD, 32'hFFF60000, 32'h000A0000);
      @(posedge clock);
      random_burst(500);
      set_box(32'h80000000, 32'h00000000, 32'h7FFFFFFF);
      @(posedge clock);
      random_burst(150);
      set_box(32'h00001000, 32'h00030000, 32'h00030000);
      @(posedge clock);
      random_burst(100);
      set_box($urandom(), 32'($signed($urandom_range(0, 200000)) - 100000),
              32'($signed($urandom_range(0, 200000)) - 100000));
      @(posedge clock);
      random_burst(180);

      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
